// ===== hdl/rtp_fragment_frame_reassembler_defines.svh =====
// Assertion macros used by the reassembler top level.
`ifndef RTP_FRAGMENT_FRAME_REASSEMBLER_DEFINES_SVH
`define RTP_FRAGMENT_FRAME_REASSEMBLER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every clock edge, reset included.
`define RFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rfr_pkg.sv =====
`default_nettype none

package rfr_pkg;

   localparam int SIZE_BITS = 24;
   localparam int KIND_W    = 4;
   localparam int SEQ_W     = 16;
   localparam int TIME_W    = 64;
   localparam int MEDIA_W   = 4;
   localparam int PAY_W     = 16;
   localparam int FRAME_W   = 24;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 24;

   localparam int BYTES_W = (SIZE_BITS > PAY_W) ? SIZE_BITS : PAY_W;
   localparam int LIM_W   = ((SIZE_BITS > FRAME_W) ? SIZE_BITS : FRAME_W) + 1;

   localparam logic [SIZE_BITS-1:0] SIZE_MASK = '1;

   localparam logic [FRAME_W-1:0] MAX_FRAME_BYTES_RESET = 24'd4194304;

   // fragment kinds
   localparam logic [KIND_W-1:0] KIND_ATOMIC = 4'h0;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 4'h1;
   localparam logic [KIND_W-1:0] KIND_LAST   = 4'h2;
   localparam logic [KIND_W-1:0] KIND_MIDDLE = 4'h3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_BYTES = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_KEY        = 4'd1;

   typedef enum logic [3:0] {
      ST_FRAME_OUT      = 4'd0,
      ST_FIRST_CACHED   = 4'd1,
      ST_MIDDLE_CACHED  = 4'd2,
      ST_EMPTY          = 4'd3,
      ST_FIRST_OVERFLOW = 4'd4,
      ST_NO_FIRST       = 4'd5,
      ST_SEQ_GAP        = 4'd6,
      ST_CTX_CHANGED    = 4'd7,
      ST_OVERFLOW       = 4'd8,
      ST_WAIT_KEY       = 4'd9,
      ST_BAD_TYPE       = 4'd10
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]  fragment_kind;
      logic [SEQ_W-1:0]   seq_number;
      logic [TIME_W-1:0]  time_stamp;
      logic [MEDIA_W-1:0] media_kind;
      logic               is_key;
      logic [PAY_W-1:0]   payload_bytes;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               frame_ready;
      logic               dropped;
      logic [FRAME_W-1:0] frame_bytes;
      logic               echo_key;
      logic [MEDIA_W-1:0] echo_media_kind;
      logic [SEQ_W-1:0]   echo_seq;
      logic [TIME_W-1:0]  echo_time;
      logic [PAY_W-1:0]   echo_payload_bytes;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_W-1:0] max_frame_bytes;
      logic               wait_for_key_frame;
   } cfg_type;

   typedef struct packed {
      logic                 assembling;
      logic [SEQ_W-1:0]     expected_seq;
      logic [TIME_W-1:0]    frame_time;
      logic [MEDIA_W-1:0]   frame_media_kind;
      logic                 seen_key_frame;
      logic [SIZE_BITS-1:0] cached_bytes;
   } ctx_type;

endpackage

`default_nettype wire

// ===== hdl/rfr_cfg_regs.sv =====
`default_nettype none

module rfr_cfg_regs
   import rfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_FRAME_BYTES: cfg_in.max_frame_bytes = FRAME_W'(csr_wdata);
            CSR_WAIT_KEY:        cfg_in.wait_for_key_frame = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_frame_bytes    <= MAX_FRAME_BYTES_RESET;
         cfg_ff.wait_for_key_frame <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rfr_decide.sv =====
`default_nettype none

module rfr_decide
   import rfr_pkg::*;
(
   input  wire req_type pkt,
   input  wire ctx_type ctx,
   input  wire cfg_type cfg,
   output rsp_type      result,
   output ctx_type      ctx_next
);

   logic [LIM_W-1:0]     limit;
   logic [LIM_W-1:0]     sum;
   logic [SIZE_BITS-1:0] sum_trunc;
   logic [SEQ_W-1:0]     seq_inc;
   logic [BYTES_W-1:0]   bytes;
   logic                 release_frame;
   status_type           status;

   assign limit = (LIM_W'(cfg.max_frame_bytes) < LIM_W'(SIZE_MASK)) ?
                  LIM_W'(cfg.max_frame_bytes) : LIM_W'(SIZE_MASK);
   assign sum       = LIM_W'(ctx.cached_bytes) + LIM_W'(pkt.payload_bytes);
   assign sum_trunc = SIZE_BITS'(sum);
   assign seq_inc   = pkt.seq_number + 16'd1;

   always_comb begin
      ctx_next      = ctx;
      status        = ST_BAD_TYPE;
      bytes         = BYTES_W'(ctx.cached_bytes);
      release_frame = 1'b0;

      if (pkt.payload_bytes == '0) begin
         status = ST_EMPTY;
      end else begin
         case (pkt.fragment_kind)
            KIND_ATOMIC: begin
               ctx_next.assembling   = 1'b0;
               ctx_next.cached_bytes = '0;
               release_frame         = 1'b1;
               bytes                 = BYTES_W'(pkt.payload_bytes);
            end
            KIND_FIRST: begin
               bytes = '0;
               if (LIM_W'(pkt.payload_bytes) > limit) begin
                  ctx_next = '0;
                  status   = ST_FIRST_OVERFLOW;
               end else begin
                  ctx_next.assembling       = 1'b1;
                  ctx_next.expected_seq     = seq_inc;
                  ctx_next.frame_time       = pkt.time_stamp;
                  ctx_next.frame_media_kind = pkt.media_kind;
                  ctx_next.cached_bytes     = SIZE_BITS'(pkt.payload_bytes);
                  status                    = ST_FIRST_CACHED;
               end
            end
            KIND_LAST, KIND_MIDDLE: begin
               if (!ctx.assembling) begin
                  status = ST_NO_FIRST;
               end else if (pkt.seq_number != ctx.expected_seq) begin
                  ctx_next = '0;
                  status   = ST_SEQ_GAP;
                  bytes    = '0;
               end else if (pkt.time_stamp != ctx.frame_time ||
                            pkt.media_kind != ctx.frame_media_kind) begin
                  ctx_next = '0;
                  status   = ST_CTX_CHANGED;
                  bytes    = '0;
               end else if (sum > limit) begin
                  ctx_next = '0;
                  status   = ST_OVERFLOW;
                  bytes    = '0;
               end else begin
                  ctx_next.expected_seq = seq_inc;
                  bytes                 = BYTES_W'(sum_trunc);
                  if (pkt.fragment_kind == KIND_LAST) begin
                     ctx_next.cached_bytes = '0;
                     ctx_next.assembling   = 1'b0;
                     release_frame         = 1'b1;
                  end else begin
                     ctx_next.cached_bytes = sum_trunc;
                     status                = ST_MIDDLE_CACHED;
                  end
               end
            end
            default: status = ST_BAD_TYPE;
         endcase
      end

      // when wait_for_key_frame is set, hold back non-key frames until a key frame has gone out
      if (release_frame) begin
         if (cfg.wait_for_key_frame && !ctx.seen_key_frame && !pkt.is_key) begin
            status = ST_WAIT_KEY;
         end else begin
            status = ST_FRAME_OUT;
            if (pkt.is_key) begin
               ctx_next.seen_key_frame = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.status             = status;
      result.frame_ready        = (status == ST_FRAME_OUT);
      result.dropped            = (status >= ST_EMPTY);
      result.frame_bytes        = FRAME_W'(bytes);
      result.echo_key           = pkt.is_key;
      result.echo_media_kind    = pkt.media_kind;
      result.echo_seq           = pkt.seq_number;
      result.echo_time          = pkt.time_stamp;
      result.echo_payload_bytes = pkt.payload_bytes;
   end

endmodule

`default_nettype wire

// ===== hdl/rtp_fragment_frame_reassembler.sv =====
// Packet-header reassembly controller: one header in, one status result out, a
// header may be offered every cycle. Each header is captured in an input
// register, decided combinationally against the frame context (sequence check,
// timestamp and media check, one byte-count add against the frame limit) and
// written to a result register that drives rsp_valid, so each result passes
// through the input register and then the result register. The combinational
// decide stage sets the rate of one header per cycle while the result side is
// not stalled; when both registers hold an item, a stall on rsp_stall
// propagates back to req_stall in the same cycle. Configuration registers take
// a write every cycle (csr_ready is always high) and must be changed only while
// no header is in flight. No initialization pass follows reset.
`default_nettype none

module rtp_fragment_frame_reassembler
   import rfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

`include "rtp_fragment_frame_reassembler_defines.svh"

   cfg_type cfg;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   ctx_type ctx_ff;

   rsp_type result;
   ctx_type ctx_next;
   logic    advance;
   logic    move;

   rfr_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfr_decide u_decide (
      .pkt      (in_data_ff),
      .ctx      (ctx_ff),
      .cfg      (cfg),
      .result   (result),
      .ctx_next (ctx_next)
   );

   // result register frees up when empty or when its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            ctx_ff <= ctx_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff <= result;
      end
   end

   `RFR_ASSERT_ALWAYS(a_stall_needs_item, clock, !in_valid_ff |-> !req_stall, "stall without item")
   `RFR_ASSERT(a_idle_no_bytes, clock, reset, !ctx_ff.assembling |-> ctx_ff.cached_bytes == '0, "bytes cached while idle")
   `RFR_ASSERT(a_first_opens, clock, reset, (move && result.status == ST_FIRST_CACHED) |=> ctx_ff.assembling, "first fragment did not open frame")
   `RFR_ASSERT(a_error_clears, clock, reset, (move && (result.status == ST_FIRST_OVERFLOW || result.status == ST_SEQ_GAP || result.status == ST_CTX_CHANGED || result.status == ST_OVERFLOW)) |=> ctx_ff == '0, "context not cleared after error")

endmodule

`default_nettype wire
